/* hdl/scr_pkg.sv */
// Shared types and constants of the segment cache replacement block.
package scr_pkg;

  localparam int unsigned ENTRIES_DEF = 64;

  localparam int unsigned SEG_W    = 16;
  localparam int unsigned OWN_W    = 8;
  localparam int unsigned HANDLE_W = 32;
  localparam int unsigned SIZE_W   = 24;
  localparam int unsigned CNT_W    = 32;
  localparam int unsigned BYTES_W  = 30;
  localparam int unsigned WGT_W    = 8;
  localparam int unsigned FAC_W    = 9;
  localparam int unsigned PROD_W   = CNT_W + FAC_W;
  localparam int unsigned SCORE_W  = PROD_W - 8;

  localparam logic [2:0] OP_INSERT    = 3'd0;
  localparam logic [2:0] OP_LOOKUP    = 3'd1;
  localparam logic [2:0] OP_REMOVE    = 3'd2;
  localparam logic [2:0] OP_LOCK      = 3'd3;
  localparam logic [2:0] OP_UNLOCK    = 3'd4;
  localparam logic [2:0] OP_FLUSH_ALL = 3'd5;
  localparam logic [2:0] OP_FLUSH_OWN = 3'd6;
  localparam logic [2:0] OP_OPTIMIZE  = 3'd7;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [1:0] ST_FULL      = 2'd2;

  localparam logic [1:0] POL_LRU  = 2'd0;
  localparam logic [1:0] POL_LFU  = 2'd1;
  localparam logic [1:0] POL_SIZE = 2'd2;
  localparam logic [1:0] POL_BAD  = 2'd3;

  localparam logic       REG_POLICY = 1'b0;
  localparam logic       REG_ENABLE = 1'b1;

  localparam logic [CNT_W-1:0]  AGE_LIMIT    = 32'd100;
  localparam logic [SIZE_W-1:0] BIG_SIZE     = 24'd16384;
  localparam logic [WGT_W-1:0]  WEIGHT_BIG   = 8'd128;
  localparam logic [WGT_W-1:0]  WEIGHT_SMALL = 8'd144;
  localparam logic [FAC_W-1:0]  WEIGHT_ONE   = 9'd256;

  typedef struct packed {
    logic [SEG_W-1:0]    seg;
    logic [OWN_W-1:0]    own;
    logic [HANDLE_W-1:0] handle;
    logic [SIZE_W-1:0]   size;
    logic [CNT_W-1:0]    uses;
    logic [CNT_W-1:0]    stamp;
    logic [WGT_W-1:0]    weight;
  } entry_t;

endpackage

/* hdl/segment_cache_replacement.sv */
// Segment cache replacement: fully associative segment table with victim choice.
//
// One item on the input channel (valid/ready) is one table operation; each item
// gives exactly one result on the output channel (valid/ready). The table works
// through its entries one at a time with a single sequencer and one entry memory
// read port, so one item is handled at a time and in_ready_o is low meanwhile.
// Immediate no-ops go straight to the result; key searches stop at the first
// match, and an insert into a free entry writes it after the search. Flushes
// make one pass over the entries; optimize makes a compaction pass and an aging
// pass; an insert that must pick a victim adds a scoring pass (one multiply per
// entry) before the write.
// The result sits in an output register; a new item is taken while it waits,
// but the block holds its next result until the receiver takes the current one.
// Configuration writes are taken at any edge with cfg_we_i high. Disabling the
// cache flushes every unlocked entry in a pass over the table during which no
// item is accepted. Reset empties the table and clears the counters.
module segment_cache_replacement
  import scr_pkg::*;
#(
  parameter int unsigned ENTRIES = ENTRIES_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic                cfg_index_i,
  input  logic [1:0]          cfg_data_i,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [2:0]          operation_i,
  input  logic [SEG_W-1:0]    segment_id_i,
  input  logic [OWN_W-1:0]    owner_tag_i,
  input  logic [HANDLE_W-1:0] handle_in_i,
  input  logic [SIZE_W-1:0]   code_size_i,
  input  logic                memory_low_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [1:0]          status_o,
  output logic                hit_o,
  output logic [HANDLE_W-1:0] handle_out_o,
  output logic [CNT_W-1:0]    hit_total_o,
  output logic [CNT_W-1:0]    miss_total_o,
  output logic [CNT_W-1:0]    evict_total_o,
  output logic [BYTES_W-1:0]  bytes_used_o
);

  localparam int unsigned IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam logic [IW-1:0] LAST = IW'(ENTRIES - 1);

  typedef enum logic [3:0] {
    S_IDLE, S_FRD, S_FEV, S_VRD, S_VRAW, S_VMUL, S_VCMP, S_INS,
    S_FLRD, S_FLEV, S_CRD, S_CEV, S_ARD, S_AEV, S_DONE
  } state_e;

  state_e state_q, state_d;

  entry_t mem [ENTRIES];
  entry_t rd_q, mem_wd;
  logic   mem_we;
  logic [IW-1:0] mem_wa;

  logic [ENTRIES-1:0] used_q, used_d, locked_q, locked_d, recent_q, recent_d;
  logic [IW-1:0] idx_q, idx_d, w_q, w_d, free_idx_q, free_idx_d;
  logic [IW-1:0] best_idx_q, best_idx_d, ins_idx_q, ins_idx_d;
  logic free_found_q, free_found_d, best_found_q, best_found_d;
  logic ins_evict_q, ins_evict_d;
  logic [SCORE_W-1:0] best_score_q, best_score_d;
  logic [SIZE_W-1:0] best_size_q, best_size_d, vsize_q, vsize_d;
  logic [CNT_W-1:0] raw_q, raw_d;
  logic [FAC_W-1:0] fac_q, fac_d;
  logic elig_q, elig_d;
  logic [PROD_W-1:0] prod_q, prod_d;

  logic [2:0] op_q, op_d;
  logic [SEG_W-1:0] seg_q, seg_d;
  logic [OWN_W-1:0] own_q, own_d;
  logic [HANDLE_W-1:0] hnd_q, hnd_d;
  logic [SIZE_W-1:0] size_q, size_d;
  logic meml_q, meml_d;
  logic flush_own_q, flush_own_d, cfg_flush_q, cfg_flush_d;
  logic flush_pend_q, flush_pend_d;

  logic [1:0] policy_q, policy_d;
  logic enable_q, enable_d;

  logic [CNT_W-1:0] clock_q, clock_d, hits_q, hits_d, miss_q, miss_d, evict_q, evict_d;
  logic [BYTES_W-1:0] bytes_q, bytes_d;

  logic [1:0] res_status_q, res_status_d;
  logic res_hit_q, res_hit_d;
  logic [HANDLE_W-1:0] res_hout_q, res_hout_d;

  logic out_valid_q, out_valid_d;
  logic [1:0] o_status_q, o_status_d;
  logic o_hit_q, o_hit_d;
  logic [HANDLE_W-1:0] o_hout_q, o_hout_d;
  logic [CNT_W-1:0] o_hits_q, o_hits_d, o_miss_q, o_miss_d, o_evict_q, o_evict_d;
  logic [BYTES_W-1:0] o_bytes_q, o_bytes_d;

  logic cur_used, cur_locked, cur_recent, key_match, aged, better, free_now;
  logic accept, evict_now, keep_recent;
  logic [CNT_W-1:0] age;
  logic [SCORE_W-1:0] score;
  logic [IW-1:0] free_pick;
  entry_t touched, fresh;

  assign accept     = in_valid_i && in_ready_o;
  assign in_ready_o = (state_q == S_IDLE) && !flush_pend_q;

  assign cur_used   = used_q[idx_q];
  assign cur_locked = locked_q[idx_q];
  assign cur_recent = recent_q[idx_q];
  assign key_match  = cur_used && (rd_q.seg == seg_q) && (rd_q.own == own_q);
  assign age        = clock_q - rd_q.stamp;
  assign aged       = age > AGE_LIMIT;
  assign score      = prod_q[PROD_W-1:8];
  assign better     = elig_q && (!best_found_q || (score > best_score_q));
  assign free_now   = free_found_q || !cur_used;
  assign free_pick  = free_found_q ? free_idx_q : idx_q;

  always_comb begin
    touched       = rd_q;
    touched.uses  = rd_q.uses + 32'd1;
    touched.stamp = clock_q;
    fresh.seg     = seg_q;
    fresh.own     = own_q;
    fresh.handle  = hnd_q;
    fresh.size    = size_q;
    fresh.uses    = 32'd1;
    fresh.stamp   = clock_q;
    fresh.weight  = (size_q > BIG_SIZE) ? WEIGHT_BIG : WEIGHT_SMALL;
  end

  always_comb begin
    state_d = state_q;
    used_d = used_q; locked_d = locked_q; recent_d = recent_q;
    idx_d = idx_q; w_d = w_q; free_idx_d = free_idx_q; free_found_d = free_found_q;
    best_idx_d = best_idx_q; best_found_d = best_found_q; best_score_d = best_score_q;
    best_size_d = best_size_q; vsize_d = vsize_q; ins_idx_d = ins_idx_q;
    ins_evict_d = ins_evict_q; raw_d = raw_q; fac_d = fac_q; elig_d = elig_q;
    prod_d = prod_q;
    op_d = op_q; seg_d = seg_q; own_d = own_q; hnd_d = hnd_q; size_d = size_q;
    meml_d = meml_q; flush_own_d = flush_own_q; cfg_flush_d = cfg_flush_q;
    flush_pend_d = flush_pend_q; policy_d = policy_q; enable_d = enable_q;
    clock_d = clock_q; hits_d = hits_q; miss_d = miss_q; evict_d = evict_q;
    bytes_d = bytes_q;
    res_status_d = res_status_q; res_hit_d = res_hit_q; res_hout_d = res_hout_q;
    out_valid_d = out_valid_q; o_status_d = o_status_q; o_hit_d = o_hit_q;
    o_hout_d = o_hout_q; o_hits_d = o_hits_q; o_miss_d = o_miss_q;
    o_evict_d = o_evict_q; o_bytes_d = o_bytes_q;
    mem_we = 1'b0; mem_wa = idx_q; mem_wd = rd_q;
    evict_now = 1'b0; keep_recent = cur_recent;

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    if (cfg_we_i) begin
      if (cfg_index_i == REG_POLICY) begin
        if (cfg_data_i != POL_BAD) begin
          policy_d = cfg_data_i;
        end
      end else begin
        enable_d = cfg_data_i[0];
        if (!cfg_data_i[0]) begin
          flush_pend_d = 1'b1;
        end
      end
    end

    case (state_q)
      S_IDLE: begin
        idx_d = '0;
        w_d = '0;
        free_found_d = 1'b0;
        best_found_d = 1'b0;
        if (flush_pend_q) begin
          flush_pend_d = cfg_we_i && (cfg_index_i == REG_ENABLE) && !cfg_data_i[0];
          flush_own_d = 1'b0;
          cfg_flush_d = 1'b1;
          state_d = S_FLRD;
        end else if (accept) begin
          op_d = operation_i; seg_d = segment_id_i; own_d = owner_tag_i;
          hnd_d = handle_in_i; size_d = code_size_i; meml_d = memory_low_i;
          res_status_d = ST_OK; res_hit_d = 1'b0; res_hout_d = '0;
          cfg_flush_d = 1'b0;
          case (operation_i)
            OP_INSERT: begin
              state_d = (!enable_q || (handle_in_i == '0)) ? S_DONE : S_FRD;
            end
            OP_LOOKUP: begin
              if (!enable_q) begin
                res_status_d = ST_NOT_FOUND;
                state_d = S_DONE;
              end else begin
                state_d = S_FRD;
              end
            end
            OP_REMOVE, OP_LOCK, OP_UNLOCK: state_d = S_FRD;
            OP_FLUSH_ALL: begin
              flush_own_d = 1'b0;
              state_d = S_FLRD;
            end
            OP_FLUSH_OWN: begin
              flush_own_d = 1'b1;
              state_d = (owner_tag_i == '0) ? S_DONE : S_FLRD;
            end
            default: state_d = S_CRD;
          endcase
        end
      end

      S_FRD: state_d = S_FEV;

      S_FEV: begin
        if (key_match) begin
          state_d = S_DONE;
          case (op_q)
            OP_INSERT, OP_LOOKUP: begin
              mem_we = 1'b1;
              mem_wd = touched;
              recent_d[idx_q] = 1'b1;
              clock_d = clock_q + 32'd1;
              hits_d = hits_q + 32'd1;
              res_hit_d = 1'b1;
              if (op_q == OP_LOOKUP) begin
                res_hout_d = rd_q.handle;
              end
            end
            OP_REMOVE: begin
              if (cur_locked) begin
                res_status_d = ST_FULL;
              end else begin
                evict_now = 1'b1;
              end
            end
            OP_LOCK:   locked_d[idx_q] = 1'b1;
            OP_UNLOCK: locked_d[idx_q] = 1'b0;
            default: ;
          endcase
        end else if (idx_q != LAST) begin
          if (!cur_used && !free_found_q) begin
            free_found_d = 1'b1;
            free_idx_d = idx_q;
          end
          idx_d = idx_q + 1'b1;
          state_d = S_FRD;
        end else begin
          case (op_q)
            OP_INSERT: begin
              if (free_now) begin
                ins_idx_d = free_pick;
                ins_evict_d = 1'b0;
                state_d = S_INS;
              end else begin
                idx_d = '0;
                state_d = S_VRD;
              end
            end
            OP_LOOKUP: begin
              miss_d = miss_q + 32'd1;
              res_status_d = ST_NOT_FOUND;
              state_d = S_DONE;
            end
            default: begin
              res_status_d = ST_NOT_FOUND;
              state_d = S_DONE;
            end
          endcase
        end
      end

      S_VRD: state_d = S_VRAW;

      S_VRAW: begin
        case (policy_q)
          POL_LRU: raw_d = clock_q - rd_q.stamp;
          POL_LFU: raw_d = ~rd_q.uses;
          default: raw_d = CNT_W'(rd_q.size);
        endcase
        fac_d = WEIGHT_ONE - FAC_W'(rd_q.weight);
        elig_d = cur_used && !cur_locked;
        vsize_d = rd_q.size;
        state_d = S_VMUL;
      end

      S_VMUL: begin
        prod_d = PROD_W'(raw_q) * PROD_W'(fac_q);
        state_d = S_VCMP;
      end

      S_VCMP: begin
        if (better) begin
          best_found_d = 1'b1;
          best_score_d = score;
          best_idx_d = idx_q;
          best_size_d = vsize_q;
        end
        if (idx_q != LAST) begin
          idx_d = idx_q + 1'b1;
          state_d = S_VRD;
        end else if (better || best_found_q) begin
          ins_idx_d = better ? idx_q : best_idx_q;
          ins_evict_d = 1'b1;
          state_d = S_INS;
        end else begin
          res_status_d = ST_FULL;
          state_d = S_DONE;
        end
      end

      S_INS: begin
        mem_we = 1'b1;
        mem_wa = ins_idx_q;
        mem_wd = fresh;
        used_d[ins_idx_q] = 1'b1;
        locked_d[ins_idx_q] = 1'b0;
        recent_d[ins_idx_q] = 1'b1;
        clock_d = clock_q + 32'd1;
        miss_d = miss_q + 32'd1;
        if (ins_evict_q) begin
          evict_d = evict_q + 32'd1;
          bytes_d = bytes_q - BYTES_W'(best_size_q) + BYTES_W'(size_q);
        end else begin
          bytes_d = bytes_q + BYTES_W'(size_q);
        end
        state_d = S_DONE;
      end

      S_FLRD: state_d = S_FLEV;

      S_FLEV: begin
        if (cur_used && !cur_locked && (!flush_own_q || (rd_q.own == own_q))) begin
          evict_now = 1'b1;
        end
        if (idx_q != LAST) begin
          idx_d = idx_q + 1'b1;
          state_d = S_FLRD;
        end else begin
          state_d = cfg_flush_q ? S_IDLE : S_DONE;
        end
      end

      S_CRD: state_d = S_CEV;

      // Compaction: a used entry moves down to the write pointer, keeping order.
      S_CEV: begin
        if (cur_used) begin
          if (w_q != idx_q) begin
            mem_we = 1'b1;
            mem_wa = w_q;
            mem_wd = rd_q;
            used_d[w_q] = 1'b1;
            locked_d[w_q] = cur_locked;
            recent_d[w_q] = cur_recent;
            used_d[idx_q] = 1'b0;
            locked_d[idx_q] = 1'b0;
            recent_d[idx_q] = 1'b0;
          end
          w_d = w_q + 1'b1;
        end
        if (idx_q != LAST) begin
          idx_d = idx_q + 1'b1;
          state_d = S_CRD;
        end else begin
          idx_d = '0;
          state_d = S_ARD;
        end
      end

      S_ARD: state_d = S_AEV;

      // Aging and, under memory pressure, eviction of stale unlocked entries.
      S_AEV: begin
        keep_recent = cur_recent && !(cur_used && aged);
        recent_d[idx_q] = keep_recent;
        if (meml_q && cur_used && !cur_locked && !keep_recent) begin
          evict_now = 1'b1;
        end
        if (idx_q != LAST) begin
          idx_d = idx_q + 1'b1;
          state_d = S_ARD;
        end else begin
          state_d = S_DONE;
        end
      end

      S_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          o_status_d = res_status_q;
          o_hit_d = res_hit_q;
          o_hout_d = res_hout_q;
          o_hits_d = hits_q;
          o_miss_d = miss_q;
          o_evict_d = evict_q;
          o_bytes_d = bytes_q;
          state_d = S_IDLE;
        end
      end

      default: state_d = S_IDLE;
    endcase

    if (evict_now) begin
      used_d[idx_q] = 1'b0;
      locked_d[idx_q] = 1'b0;
      recent_d[idx_q] = 1'b0;
      bytes_d = bytes_q - BYTES_W'(rd_q.size);
      evict_d = evict_q + 32'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    rd_q <= mem[idx_q];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      used_q <= '0; locked_q <= '0; recent_q <= '0;
      flush_pend_q <= 1'b0; cfg_flush_q <= 1'b0;
      policy_q <= POL_LRU; enable_q <= 1'b1;
      clock_q <= 32'd1; hits_q <= '0; miss_q <= '0; evict_q <= '0; bytes_q <= '0;
      out_valid_q <= 1'b0;
      idx_q <= '0; w_q <= '0; free_found_q <= 1'b0; best_found_q <= 1'b0;
    end else begin
      state_q <= state_d;
      used_q <= used_d; locked_q <= locked_d; recent_q <= recent_d;
      flush_pend_q <= flush_pend_d; cfg_flush_q <= cfg_flush_d;
      policy_q <= policy_d; enable_q <= enable_d;
      clock_q <= clock_d; hits_q <= hits_d; miss_q <= miss_d; evict_q <= evict_d;
      bytes_q <= bytes_d;
      out_valid_q <= out_valid_d;
      idx_q <= idx_d; w_q <= w_d; free_found_q <= free_found_d;
      best_found_q <= best_found_d;
    end
  end

  always_ff @(posedge clk_i) begin
    free_idx_q <= free_idx_d; best_idx_q <= best_idx_d; best_score_q <= best_score_d;
    best_size_q <= best_size_d; vsize_q <= vsize_d; ins_idx_q <= ins_idx_d;
    ins_evict_q <= ins_evict_d; raw_q <= raw_d; fac_q <= fac_d; elig_q <= elig_d;
    prod_q <= prod_d;
    op_q <= op_d; seg_q <= seg_d; own_q <= own_d; hnd_q <= hnd_d; size_q <= size_d;
    meml_q <= meml_d; flush_own_q <= flush_own_d;
    res_status_q <= res_status_d; res_hit_q <= res_hit_d; res_hout_q <= res_hout_d;
    o_status_q <= o_status_d; o_hit_q <= o_hit_d; o_hout_q <= o_hout_d;
    o_hits_q <= o_hits_d; o_miss_q <= o_miss_d; o_evict_q <= o_evict_d;
    o_bytes_q <= o_bytes_d;
  end

  assign out_valid_o   = out_valid_q;
  assign status_o      = o_status_q;
  assign hit_o         = o_hit_q;
  assign handle_out_o  = o_hout_q;
  assign hit_total_o   = o_hits_q;
  assign miss_total_o  = o_miss_q;
  assign evict_total_o = o_evict_q;
  assign bytes_used_o  = o_bytes_q;

`ifndef SYNTHESIS
  a_idle_no_evict: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE) |=> (evict_q == $past(evict_q)))
    else $error("eviction count moved while idle");

  a_hit_from_search: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (hits_q != $past(hits_q)) |-> ($past(state_q) == S_FEV))
    else $error("hit count moved outside the key search");

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (state_q != S_IDLE))
    else $error("accepted item did not start work");
`endif

endmodule

/* bench/tb.sv */
// Self-checking testbench for the segment cache replacement block.
`timescale 1ns / 1ps

module tb
  import scr_pkg::*;
();

  localparam int unsigned NUM_ENTRIES = ENTRIES_DEF;

  typedef struct {
    logic [2:0]          op;
    logic [SEG_W-1:0]    seg;
    logic [OWN_W-1:0]    own;
    logic [HANDLE_W-1:0] handle;
    logic [SIZE_W-1:0]   size;
    logic                mem_low;
  } table_op_t;

  typedef struct {
    logic [1:0]          status;
    logic                hit;
    logic [HANDLE_W-1:0] handle;
    logic [CNT_W-1:0]    hits;
    logic [CNT_W-1:0]    misses;
    logic [CNT_W-1:0]    evicts;
    logic [BYTES_W-1:0]  bytes;
  } op_answer_t;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                cfg_we_i = 1'b0;
  logic                cfg_index_i = 1'b0;
  logic [1:0]          cfg_data_i = '0;
  logic                in_valid_i = 1'b0;
  logic                in_ready_o;
  logic [2:0]          operation_i = OP_INSERT;
  logic [SEG_W-1:0]    segment_id_i = '0;
  logic [OWN_W-1:0]    owner_tag_i = '0;
  logic [HANDLE_W-1:0] handle_in_i = '0;
  logic [SIZE_W-1:0]   code_size_i = '0;
  logic                memory_low_i = 1'b0;
  logic                out_valid_o;
  logic                out_ready_i = 1'b0;
  logic [1:0]          status_o;
  logic                hit_o;
  logic [HANDLE_W-1:0] handle_out_o;
  logic [CNT_W-1:0]    hit_total_o;
  logic [CNT_W-1:0]    miss_total_o;
  logic [CNT_W-1:0]    evict_total_o;
  logic [BYTES_W-1:0]  bytes_used_o;

  segment_cache_replacement i_dut (.*);

  always #5 clk_i = ~clk_i;

  // Shadow copy of the segment table.
  logic                tab_used   [NUM_ENTRIES];
  logic                tab_locked [NUM_ENTRIES];
  logic                tab_recent [NUM_ENTRIES];
  logic [SEG_W-1:0]    tab_seg    [NUM_ENTRIES];
  logic [OWN_W-1:0]    tab_own    [NUM_ENTRIES];
  logic [HANDLE_W-1:0] tab_handle [NUM_ENTRIES];
  logic [SIZE_W-1:0]   tab_size   [NUM_ENTRIES];
  logic [CNT_W-1:0]    tab_uses   [NUM_ENTRIES];
  logic [CNT_W-1:0]    tab_stamp  [NUM_ENTRIES];
  logic [WGT_W-1:0]    tab_weight [NUM_ENTRIES];
  logic [CNT_W-1:0]    clock_now, hit_cnt, miss_cnt, evict_cnt;
  logic [BYTES_W-1:0]  byte_cnt;
  logic [1:0]          policy_now;
  logic                enabled_now;

  table_op_t  pending_ops[$];
  op_answer_t expected_answers[$];
  table_op_t  cur_op;
  int         errors = 0;
  int         burst_left = 0;
  int         gap_left = 0;
  int         stall_left = 0;
  int         stall_mode = 0;
  int         mode_cycles = 0;

  function automatic void clear_slot(int i);
    tab_used[i] = 0; tab_locked[i] = 0; tab_recent[i] = 0;
    tab_seg[i] = '0; tab_own[i] = '0; tab_handle[i] = '0; tab_size[i] = '0;
    tab_uses[i] = '0; tab_stamp[i] = '0; tab_weight[i] = '0;
  endfunction

  function automatic void evict_slot(int i);
    byte_cnt = byte_cnt - BYTES_W'(tab_size[i]);
    evict_cnt++;
    clear_slot(i);
  endfunction

  function automatic void flush_unlocked_slots();
    for (int i = 0; i < NUM_ENTRIES; i++)
      if (tab_used[i] && !tab_locked[i]) evict_slot(i);
  endfunction

  function automatic int find_slot(logic [SEG_W-1:0] seg, logic [OWN_W-1:0] own);
    for (int i = 0; i < NUM_ENTRIES; i++)
      if (tab_used[i] && tab_seg[i] == seg && tab_own[i] == own) return i;
    return -1;
  endfunction

  // Largest weighted score wins; the first index wins a tie.
  function automatic int choose_victim();
    int         best;
    logic [63:0] raw, score, best_score;
    best = -1;
    best_score = '0;
    for (int i = 0; i < NUM_ENTRIES; i++) begin
      if (!tab_used[i] || tab_locked[i]) continue;
      if (policy_now == POL_LRU) raw = 64'(clock_now - tab_stamp[i]);
      else if (policy_now == POL_LFU) raw = 64'(32'hFFFF_FFFF - tab_uses[i]);
      else raw = 64'(tab_size[i]);
      score = (raw * (64'd256 - 64'(tab_weight[i]))) >> 8;
      if (best < 0 || score > best_score) begin
        best = i;
        best_score = score;
      end
    end
    return best;
  endfunction

  function automatic void touch_slot(int i);
    tab_uses[i]++;
    tab_stamp[i] = clock_now;
    clock_now++;
    tab_recent[i] = 1;
    hit_cnt++;
  endfunction

  function automatic void reset_table();
    for (int i = 0; i < NUM_ENTRIES; i++) clear_slot(i);
    clock_now = 1; hit_cnt = 0; miss_cnt = 0; evict_cnt = 0; byte_cnt = 0;
    policy_now = POL_LRU;
    enabled_now = 1;
  endfunction

  function automatic op_answer_t apply_table_op(table_op_t t);
    op_answer_t a;
    int         e, w;
    a.status = ST_OK; a.hit = 0; a.handle = '0;
    case (t.op)
      OP_INSERT: begin
        if (enabled_now && t.handle != 0) begin
          e = find_slot(t.seg, t.own);
          if (e >= 0) begin
            touch_slot(e);
            a.hit = 1;
          end else begin
            for (int i = 0; i < NUM_ENTRIES && e < 0; i++)
              if (!tab_used[i]) e = i;
            if (e < 0) begin
              e = choose_victim();
              if (e >= 0) evict_slot(e);
            end
            if (e < 0) a.status = ST_FULL;
            else begin
              tab_used[e] = 1; tab_locked[e] = 0; tab_recent[e] = 1;
              tab_seg[e] = t.seg; tab_own[e] = t.own; tab_handle[e] = t.handle;
              tab_size[e] = t.size; tab_uses[e] = 1; tab_stamp[e] = clock_now;
              clock_now++;
              tab_weight[e] = (t.size > BIG_SIZE) ? WEIGHT_BIG : WEIGHT_SMALL;
              byte_cnt = byte_cnt + BYTES_W'(t.size);
              miss_cnt++;
            end
          end
        end
      end
      OP_LOOKUP: begin
        if (!enabled_now) a.status = ST_NOT_FOUND;
        else begin
          e = find_slot(t.seg, t.own);
          if (e < 0) begin
            miss_cnt++;
            a.status = ST_NOT_FOUND;
          end else begin
            touch_slot(e);
            a.hit = 1;
            a.handle = tab_handle[e];
          end
        end
      end
      OP_REMOVE: begin
        e = find_slot(t.seg, t.own);
        if (e < 0) a.status = ST_NOT_FOUND;
        else if (tab_locked[e]) a.status = ST_FULL;
        else evict_slot(e);
      end
      OP_LOCK, OP_UNLOCK: begin
        e = find_slot(t.seg, t.own);
        if (e < 0) a.status = ST_NOT_FOUND;
        else tab_locked[e] = (t.op == OP_LOCK);
      end
      OP_FLUSH_ALL: flush_unlocked_slots();
      OP_FLUSH_OWN: begin
        if (t.own != 0)
          for (int i = 0; i < NUM_ENTRIES; i++)
            if (tab_used[i] && !tab_locked[i] && tab_own[i] == t.own) evict_slot(i);
      end
      default: begin
        w = 0;
        for (int r = 0; r < NUM_ENTRIES; r++) begin
          if (!tab_used[r]) continue;
          if (w != r) begin
            tab_used[w] = 1; tab_locked[w] = tab_locked[r]; tab_recent[w] = tab_recent[r];
            tab_seg[w] = tab_seg[r]; tab_own[w] = tab_own[r];
            tab_handle[w] = tab_handle[r]; tab_size[w] = tab_size[r];
            tab_uses[w] = tab_uses[r]; tab_stamp[w] = tab_stamp[r];
            tab_weight[w] = tab_weight[r];
            clear_slot(r);
          end
          w++;
        end
        for (int i = 0; i < NUM_ENTRIES; i++)
          if (tab_used[i] && tab_recent[i] && (clock_now - tab_stamp[i]) > AGE_LIMIT)
            tab_recent[i] = 0;
        if (t.mem_low)
          for (int i = 0; i < NUM_ENTRIES; i++)
            if (tab_used[i] && !tab_locked[i] && !tab_recent[i]) evict_slot(i);
      end
    endcase
    a.hits = hit_cnt; a.misses = miss_cnt; a.evicts = evict_cnt; a.bytes = byte_cnt;
    return a;
  endfunction

  function automatic table_op_t mk_op(logic [2:0] op, logic [SEG_W-1:0] seg,
                                      logic [OWN_W-1:0] own, logic [HANDLE_W-1:0] handle,
                                      logic [SIZE_W-1:0] size, logic mem_low);
    table_op_t t;
    t.op = op; t.seg = seg; t.own = own; t.handle = handle; t.size = size;
    t.mem_low = mem_low;
    return t;
  endfunction

  // Segment ids come mostly from a pool a little larger than the table, so hits,
  // full-table victim choice and owner flushes all happen often.
  function automatic table_op_t random_op();
    table_op_t t;
    int        pick;
    pick = $urandom_range(0, 99);
    if (pick < 40) t.op = OP_INSERT;
    else if (pick < 65) t.op = OP_LOOKUP;
    else if (pick < 72) t.op = OP_REMOVE;
    else if (pick < 79) t.op = OP_LOCK;
    else if (pick < 86) t.op = OP_UNLOCK;
    else if (pick < 88) t.op = OP_FLUSH_ALL;
    else if (pick < 92) t.op = OP_FLUSH_OWN;
    else t.op = OP_OPTIMIZE;
    if ($urandom_range(0, 9) == 0) t.seg = SEG_W'($urandom);
    else t.seg = SEG_W'($urandom_range(0, 79) * 821);
    case ($urandom_range(0, 4))
      0: t.own = 8'd0;
      1: t.own = 8'd1;
      2: t.own = 8'd2;
      3: t.own = 8'd255;
      default: t.own = OWN_W'($urandom);
    endcase
    t.handle = ($urandom_range(0, 19) == 0) ? '0 : HANDLE_W'($urandom);
    case ($urandom_range(0, 3))
      0: t.size = SIZE_W'($urandom);
      1: t.size = SIZE_W'($urandom_range(16380, 16390));
      default: t.size = SIZE_W'($urandom_range(0, 20000));
    endcase
    t.mem_low = 1'($urandom_range(0, 1));
    return t;
  endfunction

  task automatic report_mismatch(string field, logic [63:0] got, logic [63:0] want);
    $display("tb: %s mismatch at %0t: got %0h, expected %0h", field, $realtime, got, want);
    errors++;
  endtask

  // Waits until no item is pending or in flight and the block is idle.
  task automatic wait_drained();
    while (pending_ops.size() != 0 || in_valid_i || expected_answers.size() != 0 ||
           !in_ready_o)
      @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  // Registers are written only while the block is idle.
  task automatic write_reg(logic idx, logic [1:0] data);
    wait_drained();
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    if (idx == REG_POLICY) begin
      if (data != POL_BAD) policy_now = data;
    end else begin
      enabled_now = data[0];
      if (!enabled_now) flush_unlocked_slots();
    end
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic random_phase(int count);
    repeat (count) pending_ops.push_back(random_op());
  endtask

  // Sender: bursts of random length separated by random gaps.
  always @(posedge clk_i) begin
    if (in_valid_i && in_ready_o)
      expected_answers.push_back(apply_table_op(cur_op));
    if (in_valid_i && !in_ready_o) begin
      // Hold the item until it is taken.
    end else if (gap_left > 0) begin
      gap_left--;
      in_valid_i <= 1'b0;
    end else if (pending_ops.size() != 0 && rst_ni) begin
      cur_op = pending_ops.pop_front();
      in_valid_i <= 1'b1;
      operation_i <= cur_op.op;
      segment_id_i <= cur_op.seg;
      owner_tag_i <= cur_op.own;
      handle_in_i <= cur_op.handle;
      code_size_i <= cur_op.size;
      memory_low_i <= cur_op.mem_low;
      if (burst_left > 0) burst_left--;
      else begin
        burst_left = $urandom_range(0, 12);
        gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 30);
      end
    end else begin
      in_valid_i <= 1'b0;
    end
  end

  // Receiver: stall behavior switches among always ready, random stalls and stall bursts.
  always @(posedge clk_i) begin
    if (mode_cycles == 0) begin
      mode_cycles = $urandom_range(100, 600);
      stall_mode = $urandom_range(0, 2);
    end else mode_cycles--;
    if (stall_left > 0) begin
      stall_left--;
      out_ready_i <= 1'b0;
    end else if (stall_mode == 1 && $urandom_range(0, 1) == 0) begin
      out_ready_i <= 1'b0;
    end else if (stall_mode == 2 && $urandom_range(0, 7) == 0) begin
      stall_left = $urandom_range(1, 20);
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    op_answer_t want;
    if (out_valid_o && out_ready_i) begin
      if (expected_answers.size() == 0) begin
        report_mismatch("unexpected result", {62'd0, status_o}, 64'd0);
      end else begin
        want = expected_answers.pop_front();
        if (status_o !== want.status) report_mismatch("status", status_o, want.status);
        if (hit_o !== want.hit) report_mismatch("hit", hit_o, want.hit);
        if (handle_out_o !== want.handle) report_mismatch("handle_out", handle_out_o, want.handle);
        if (hit_total_o !== want.hits) report_mismatch("hit_total", hit_total_o, want.hits);
        if (miss_total_o !== want.misses)
          report_mismatch("miss_total", miss_total_o, want.misses);
        if (evict_total_o !== want.evicts)
          report_mismatch("evict_total", evict_total_o, want.evicts);
        if (bytes_used_o !== want.bytes) report_mismatch("bytes_used", bytes_used_o, want.bytes);
      end
    end
  end

  initial begin
    reset_table();
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: field extremes, every operation and the special cases.
    pending_ops.push_back(mk_op(OP_INSERT, 16'hFFFF, 8'hFF, 32'hFFFF_FFFF, 24'hFF_FFFF, 1));
    pending_ops.push_back(mk_op(OP_LOOKUP, 16'hFFFF, 8'hFF, '0, '0, 0));
    pending_ops.push_back(mk_op(OP_INSERT, 16'hFFFF, 8'hFF, 32'h1, 24'd5, 0));
    pending_ops.push_back(mk_op(OP_LOOKUP, 16'h0000, 8'h00, '0, '0, 0));
    pending_ops.push_back(mk_op(OP_INSERT, 16'h0000, 8'h00, '0, 24'd9, 0));
    pending_ops.push_back(mk_op(OP_INSERT, 16'h0000, 8'h00, 32'h5, 24'd16384, 0));
    pending_ops.push_back(mk_op(OP_INSERT, 16'h0001, 8'h01, 32'h6, 24'd16385, 0));
    pending_ops.push_back(mk_op(OP_LOCK, 16'h0001, 8'h01, '0, '0, 0));
    pending_ops.push_back(mk_op(OP_REMOVE, 16'h0001, 8'h01, '0, '0, 0));
    pending_ops.push_back(mk_op(OP_LOCK, 16'h0002, 8'h01, '0, '0, 0));
    pending_ops.push_back(mk_op(OP_UNLOCK, 16'h0002, 8'h01, '0, '0, 0));
    pending_ops.push_back(mk_op(OP_FLUSH_OWN, '0, 8'h00, '0, '0, 0));
    pending_ops.push_back(mk_op(OP_FLUSH_OWN, '0, 8'h01, '0, '0, 0));
    pending_ops.push_back(mk_op(OP_UNLOCK, 16'h0001, 8'h01, '0, '0, 0));
    pending_ops.push_back(mk_op(OP_FLUSH_OWN, '0, 8'h01, '0, '0, 0));
    pending_ops.push_back(mk_op(OP_OPTIMIZE, '0, '0, '0, '0, 0));
    pending_ops.push_back(mk_op(OP_OPTIMIZE, '0, '0, '0, '0, 1));
    pending_ops.push_back(mk_op(OP_REMOVE, 16'h0000, 8'h00, '0, '0, 0));
    pending_ops.push_back(mk_op(OP_REMOVE, 16'h0000, 8'h00, '0, '0, 0));
    pending_ops.push_back(mk_op(OP_FLUSH_ALL, '0, '0, '0, '0, 0));

    // Lock a full table so that an insert miss finds no victim.
    for (int i = 0; i < NUM_ENTRIES; i++)
      pending_ops.push_back(mk_op(OP_INSERT, SEG_W'(i), 8'h3, 32'h100 + i, 24'(i), 0));
    for (int i = 0; i < NUM_ENTRIES; i++)
      pending_ops.push_back(mk_op(OP_LOCK, SEG_W'(i), 8'h3, '0, '0, 0));
    pending_ops.push_back(mk_op(OP_INSERT, 16'h7777, 8'h3, 32'h9, 24'd1, 0));
    for (int i = 0; i < NUM_ENTRIES; i++)
      pending_ops.push_back(mk_op(OP_UNLOCK, SEG_W'(i), 8'h3, '0, '0, 0));

    random_phase(300);
    write_reg(REG_POLICY, POL_LFU);
    random_phase(300);
    write_reg(REG_POLICY, POL_SIZE);
    random_phase(300);
    write_reg(REG_POLICY, POL_BAD);
    random_phase(150);
    write_reg(REG_ENABLE, 1'b0);
    random_phase(60);
    write_reg(REG_ENABLE, 1'b0);
    write_reg(REG_ENABLE, 1'b1);
    write_reg(REG_POLICY, POL_LRU);
    random_phase(300);

    wait_drained();
    repeat (500) @(posedge clk_i);
    if (errors == 0 && expected_answers.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin
    #50ms;
    $display("tb: failure");
    $finish;
  end

endmodule
